// ----- rtl/pal_pkg.sv -----
// types and codes shared by the positional array list block
package pal_pkg;

   // command codes
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_POS   = 3'd1;
   localparam logic [2:0] CMD_INS_END   = 3'd2;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [2:0] CMD_DEL_POS   = 3'd4;
   localparam logic [2:0] CMD_DEL_END   = 3'd5;
   localparam logic [2:0] CMD_READ      = 3'd6;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   // request item
   typedef struct packed {
      logic [2:0]         cmd;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   // response item
   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         count_after;
      logic signed [31:0] read_value;
   } rsp_type;

endpackage

// ----- rtl/pal_ram.sv -----
// generic single write port, single read port ram with registered read
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/positional_array_list_unit.sv -----
// top level of the positional array list: command decode, shift sequencer, result register
//
// Keeps a dense ordered list of signed 32-bit values in a ram of CAPACITY words plus a
// fill count. Each request item carries a command (insert front / at position / at end,
// delete front / at position / at end, read at position), a position and a value. Each
// request gives exactly one response item: status, count after the command and, for a
// successful read, the value read (zero otherwise). A failed command changes nothing.
// Items on both channels move on a valid/stall handshake; one item is worked at a time
// and req_stall is high from acceptance until its response has been loaded into the
// output register.
// A failed command goes straight to the result register, and a read does one ram read.
// An insert or delete moves one entry per cycle through the single ram port pair, at most
// CAPACITY - 1 entries, for an insert at the front of a nearly full list or a delete at
// the front of a full one.
// The next item can be accepted in the cycle after the response is loaded into the output
// register.
// The result register lets a new item be accepted while the previous response is still
// held under rsp_stall; a finished result then waits until the output register frees.
// Reset empties the list (count zero); ram contents are not cleared and are never read
// above the count.
module positional_array_list_unit #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pal_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 7) ? CW : 7;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_RWAIT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             ins_ff, ins_in;
   logic [AW-1:0]    p_ff, p_in;
   logic [31:0]      val_ff, val_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in;
   pal_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pal_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [31:0]      ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [31:0]      ram_rd_data;

   logic             accept;
   logic             is_ins, is_del, is_rd;
   logic             full, empty;
   logic [XW-1:0]    pos_x, cnt_x, ins_p_x, del_p_x, new_cnt_x;
   logic             rsp_free;

   // entry store
   pal_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // command decode
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign is_ins   = (req_data.cmd == pal_pkg::CMD_INS_FRONT) ||
                     (req_data.cmd == pal_pkg::CMD_INS_POS) ||
                     (req_data.cmd == pal_pkg::CMD_INS_END);
   assign is_del   = (req_data.cmd == pal_pkg::CMD_DEL_FRONT) ||
                     (req_data.cmd == pal_pkg::CMD_DEL_POS) ||
                     (req_data.cmd == pal_pkg::CMD_DEL_END);
   assign is_rd    = (req_data.cmd == pal_pkg::CMD_READ);
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign pos_x    = XW'(req_data.position);
   assign cnt_x    = XW'(count_ff);
   assign ins_p_x  = (req_data.cmd == pal_pkg::CMD_INS_FRONT) ? '0 :
                     (req_data.cmd == pal_pkg::CMD_INS_END)   ? cnt_x : pos_x;
   // delete end is only taken when the list is not empty
   assign del_p_x  = (req_data.cmd == pal_pkg::CMD_DEL_FRONT) ? '0 :
                     (req_data.cmd == pal_pkg::CMD_DEL_END)   ? cnt_x - XW'(1) : pos_x;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ins_in       = ins_ff;
      p_in         = p_ff;
      val_in       = val_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      rd_addr_in   = rd_addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = rd_addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cur_ff;
      new_cnt_x    = cnt_x;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in.read_value  = '0;
               res_in.count_after = cnt_x[6:0];
               res_in.status      = pal_pkg::ST_OK;
               val_in             = req_data.value;
               pend_in            = 1'b0;
               state_in           = S_DONE;
               if (is_ins) begin
                  if (full) begin
                     res_in.status = pal_pkg::ST_FULL;
                  end else if (ins_p_x > cnt_x) begin
                     res_in.status = pal_pkg::ST_BADPOS;
                  end else begin
                     // move entries p..count-1 up by one, top first
                     ins_in   = 1'b1;
                     p_in     = AW'(ins_p_x);
                     cur_in   = AW'(cnt_x - XW'(1));
                     rem_in   = CW'(cnt_x - ins_p_x);
                     state_in = S_SHIFT;
                  end
               end else if (is_del || is_rd) begin
                  if (empty) begin
                     res_in.status = pal_pkg::ST_EMPTY;
                  end else if (del_p_x >= cnt_x) begin
                     res_in.status = pal_pkg::ST_BADPOS;
                  end else if (is_rd) begin
                     p_in     = AW'(del_p_x);
                     state_in = S_READ;
                  end else begin
                     // move entries p+1..count-1 down by one, bottom first
                     ins_in   = 1'b0;
                     p_in     = AW'(del_p_x);
                     cur_in   = AW'(del_p_x + XW'(1));
                     rem_in   = CW'(cnt_x - XW'(1) - del_p_x);
                     state_in = S_SHIFT;
                  end
               end else begin
                  res_in.status = pal_pkg::ST_BADPOS;
               end
            end
         end
         S_SHIFT: begin
            // write back the word read in the previous cycle
            ram_wr_en   = pend_ff;
            ram_wr_addr = ins_ff ? rd_addr_ff + AW'(1) : rd_addr_ff - AW'(1);
            ram_wr_data = ram_rd_data;
            // read the next word to move
            if (rem_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cur_ff;
               rd_addr_in  = cur_ff;
               cur_in      = ins_ff ? cur_ff - AW'(1) : cur_ff + AW'(1);
               rem_in      = rem_ff - CW'(1);
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            // all moved: place the new value or drop the last slot
            if ((rem_ff == '0) && !pend_ff) begin
               if (ins_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = p_ff;
                  ram_wr_data = val_ff;
                  new_cnt_x   = cnt_x + XW'(1);
               end else begin
                  new_cnt_x   = cnt_x - XW'(1);
               end
               count_in           = CW'(new_cnt_x);
               res_in.count_after = new_cnt_x[6:0];
               state_in           = S_DONE;
            end
         end
         S_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = p_ff;
            state_in    = S_RWAIT;
         end
         S_RWAIT: begin
            res_in.read_value = ram_rd_data;
            state_in          = S_DONE;
         end
         S_DONE: begin
            // hand the result to the output register once it is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ins_ff      <= ins_in;
      p_ff        <= p_in;
      val_ff      <= val_in;
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      rd_addr_ff  <= rd_addr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
